// File: design/h264sps_pkg.sv
// Package for the H.264 SPS dimension parser: parse steps, field kinds,
// sequencer states, status codes and helper functions. No dependencies.
`default_nettype none
package h264sps_pkg;

  localparam int MaxCodeZeros = 32;
  localparam logic [3:0] HeaderBytesReset = 4'd5;

  typedef enum logic [5:0] {
    ST_PROFILE    = 6'd0,  ST_CONSTR     = 6'd1,  ST_LEVEL      = 6'd2,
    ST_SPS_ID     = 6'd3,  ST_CHROMA     = 6'd4,  ST_SEP_PLANE  = 6'd5,
    ST_DEPTH_L    = 6'd6,  ST_DEPTH_C    = 6'd7,  ST_BYPASS     = 6'd8,
    ST_MATRIX     = 6'd9,  ST_LIST_FLAG  = 6'd10, ST_DELTA      = 6'd11,
    ST_LOG2_FRAME = 6'd12, ST_POC_TYPE   = 6'd13, ST_POC_LSB    = 6'd14,
    ST_DELTA_ZERO = 6'd15, ST_OFF_NONREF = 6'd16, ST_OFF_TB     = 6'd17,
    ST_CYCLE_N    = 6'd18, ST_CYCLE_OFF  = 6'd19, ST_MAX_REFS   = 6'd20,
    ST_GAPS       = 6'd21, ST_WIDTH      = 6'd22, ST_HEIGHT     = 6'd23,
    ST_FRAME_ONLY = 6'd24, ST_MBAFF      = 6'd25, ST_DIRECT     = 6'd26,
    ST_CROP       = 6'd27, ST_CROP_L     = 6'd28, ST_CROP_R     = 6'd29,
    ST_CROP_T     = 6'd30, ST_CROP_B     = 6'd31, ST_VUI        = 6'd32,
    ST_DONE       = 6'd33
  } step_t;

  typedef enum logic [2:0] {
    K_FLAG = 3'd0, K_BYTE = 3'd1, K_UE = 3'd2, K_SE = 3'd3, K_NONE = 3'd4
  } kind_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_ERR   = 2'd2;

  // Sequencer control state, one-hot
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_BITS = 3'b010,
    SEQ_OUT  = 3'b100
  } seq_t;

  function automatic kind_t kind_of(input step_t s);
    kind_t k;
    case (s)
      ST_PROFILE, ST_CONSTR, ST_LEVEL: k = K_BYTE;
      ST_SEP_PLANE, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DELTA_ZERO,
      ST_GAPS, ST_FRAME_ONLY, ST_MBAFF, ST_DIRECT, ST_CROP, ST_VUI: k = K_FLAG;
      ST_DELTA, ST_OFF_NONREF, ST_OFF_TB, ST_CYCLE_OFF: k = K_SE;
      ST_DONE: k = K_NONE;
      default: k = K_UE;
    endcase
    return k;
  endfunction

  function automatic logic is_high_profile(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
           p == 8'd44  || p == 8'd83  || p == 8'd86  || p == 8'd118;
  endfunction

endpackage
`default_nettype wire

// File: design/h264_sps_dimension_parser_top.sv
// Top level of the H.264 SPS dimension parser: byte stream in, size out.
// Depends on h264sps_pkg.
// A skipped byte is consumed on its transfer alone; a parsed byte is then worked bit by bit,
// MSB first, through the shared Exp-Golomb shift/accumulate unit.
// A last byte then runs the size arithmetic before the result is offered.
// While a byte's bits are parsed or a result is pending, the input is not ready.
// Reset (synchronous, rst_n low): parse state cleared, header_bytes = 5.
`default_nettype none
module h264_sps_dimension_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] sps_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] pic_width, [31:16] pic_height,
                                       // [33:32] status, [39:34] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data    // header_bytes
);

  h264sps_pkg::seq_t  seq_r, seq_nxt;
  h264sps_pkg::step_t step_r, step_nxt;

  logic [3:0]  hdr_r;
  logic [3:0]  skip_r, skip_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [5:0]  zrun_r, zrun_nxt;
  logic [31:0] code_r, code_nxt;
  logic [5:0]  left_r, left_nxt;
  logic [3:0]  list_r, list_nxt;
  logic [6:0]  entry_r, entry_nxt;
  logic [7:0]  lscale_r, lscale_nxt;
  logic [7:0]  nscale_r, nscale_nxt;
  logic [7:0]  ccount_r, ccount_nxt;
  logic [7:0]  prof_r, prof_nxt;
  logic        fonly_r, fonly_nxt;
  logic [15:0] wmb_r, wmb_nxt;
  logic [15:0] hun_r, hun_nxt;
  logic [15:0] crop_r [4];
  logic [15:0] crop_nxt [4];
  logic [1:0]  err_r, err_nxt;
  // result arithmetic: 3-step sequence, sums through the shared sum_a/sum_b adders
  logic [1:0]  ostep_r, ostep_nxt;
  logic [19:0] wacc_r, wacc_nxt;
  logic [19:0] hacc_r, hacc_nxt;
  logic [39:0] odata_r, odata_nxt;

  // one bit of parse work
  logic        cur_bit;
  logic        have_v;
  logic [32:0] v;
  logic [32:0] ue_v;
  logic [31:0] code_sh;
  h264sps_pkg::kind_t kind;
  logic [7:0]  nsum;
  logic [19:0] sum_a, sum_b, sum_o;

  assign in_tready  = (seq_r == h264sps_pkg::SEQ_IDLE);
  assign cfg_ready  = (seq_r == h264sps_pkg::SEQ_IDLE);
  assign out_tvalid = (seq_r == h264sps_pkg::SEQ_OUT) && (ostep_r == 2'd3);
  assign out_tdata  = odata_r;

  assign cur_bit = byte_r[3'd7 - bit_r];
  assign code_sh = {code_r[30:0], cur_bit};
  assign kind    = h264sps_pkg::kind_of(step_r);
  assign ue_v    = ((33'd1 << zrun_r) - 33'd1) + {1'b0, code_sh};
  assign nsum    = lscale_r + v[7:0];

  // adders shared by the width and height sums, selected by ostep
  always_comb begin
    sum_a = wacc_r;
    sum_b = hacc_r;
    case (ostep_r)
      2'd0: begin
        sum_a = {4'd0, wmb_r} + 20'd1;
        sum_b = {4'd0, crop_r[0]} + {4'd0, crop_r[1]};
      end
      2'd1: begin
        sum_a = {4'd0, hun_r} + 20'd1;
        sum_b = {4'd0, crop_r[2]} + {4'd0, crop_r[3]};
      end
      default: begin
        sum_a = wacc_r;
        sum_b = hacc_r;
      end
    endcase
    sum_o = sum_a + sum_b;
  end

  always_comb begin
    logic [20:0] w, wc;
    logic [21:0] h, hc;
    logic        ovf;
    seq_nxt = seq_r;  step_nxt = step_r;  skip_nxt = skip_r;
    byte_nxt = byte_r; last_nxt = last_r; bit_nxt = bit_r;
    zrun_nxt = zrun_r; code_nxt = code_r; left_nxt = left_r;
    list_nxt = list_r; entry_nxt = entry_r; lscale_nxt = lscale_r;
    nscale_nxt = nscale_r; ccount_nxt = ccount_r; prof_nxt = prof_r;
    fonly_nxt = fonly_r; wmb_nxt = wmb_r; hun_nxt = hun_r;
    for (int i = 0; i < 4; i++) crop_nxt[i] = crop_r[i];
    err_nxt = err_r; ostep_nxt = ostep_r; wacc_nxt = wacc_r;
    hacc_nxt = hacc_r; odata_nxt = odata_r;
    have_v = 1'b0; v = '0;
    w = '0; h = '0; wc = '0; hc = '0; ovf = 1'b0;

    case (seq_r)
      h264sps_pkg::SEQ_IDLE: begin
        if (in_tvalid) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          bit_nxt  = 3'd0;
          ostep_nxt = 2'd0;
          if (skip_r < hdr_r) begin
            skip_nxt = skip_r + 4'd1;
            seq_nxt  = in_tlast ? h264sps_pkg::SEQ_OUT : h264sps_pkg::SEQ_IDLE;
          end else begin
            seq_nxt = h264sps_pkg::SEQ_BITS;
          end
        end
      end

      h264sps_pkg::SEQ_BITS: begin
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7)
          seq_nxt = last_r ? h264sps_pkg::SEQ_OUT : h264sps_pkg::SEQ_IDLE;
        if (err_r == h264sps_pkg::STATUS_OK && step_r != h264sps_pkg::ST_DONE) begin
          case (kind)
            h264sps_pkg::K_FLAG: begin
              have_v = 1'b1;
              v = {32'd0, cur_bit};
            end
            h264sps_pkg::K_BYTE: begin
              code_nxt = code_sh;
              if (left_r == 6'd0) begin
                left_nxt = 6'd7;
              end else begin
                left_nxt = left_r - 6'd1;
                if (left_r == 6'd1) begin
                  have_v = 1'b1;
                  v = {1'b0, code_sh};
                end
              end
            end
            h264sps_pkg::K_UE, h264sps_pkg::K_SE: begin
              if (left_r == 6'd0) begin
                if (!cur_bit) begin
                  zrun_nxt = zrun_r + 6'd1;
                  if ({26'd0, zrun_nxt} >= h264sps_pkg::MaxCodeZeros)
                    err_nxt = h264sps_pkg::STATUS_ERR;
                end else if (zrun_r != 6'd0) begin
                  left_nxt = zrun_r;
                  code_nxt = '0;
                end else begin
                  have_v = 1'b1;
                  v = '0;
                end
              end else begin
                code_nxt = code_sh;
                left_nxt = left_r - 6'd1;
                if (left_r == 6'd1) begin
                  have_v = 1'b1;
                  v = ue_v;
                end
              end
              if (have_v && kind == h264sps_pkg::K_SE) begin
                if (v[0]) v = (v + 33'd1) >> 1;
                else      v = {1'b0, 32'd0 - v[32:1]};
              end
            end
            default: ;
          endcase

          if (have_v) begin
            code_nxt = '0;
            zrun_nxt = '0;
            left_nxt = '0;
            case (step_r)
              h264sps_pkg::ST_PROFILE: begin
                prof_nxt = v[7:0];
                step_nxt = h264sps_pkg::ST_CONSTR;
              end
              h264sps_pkg::ST_CONSTR: step_nxt = h264sps_pkg::ST_LEVEL;
              h264sps_pkg::ST_LEVEL:  step_nxt = h264sps_pkg::ST_SPS_ID;
              h264sps_pkg::ST_SPS_ID:
                step_nxt = h264sps_pkg::is_high_profile(prof_r) ?
                           h264sps_pkg::ST_CHROMA : h264sps_pkg::ST_LOG2_FRAME;
              h264sps_pkg::ST_CHROMA: begin
                ccount_nxt = (v == 33'd3) ? 8'd12 : 8'd8;
                step_nxt = (v == 33'd3) ? h264sps_pkg::ST_SEP_PLANE :
                                          h264sps_pkg::ST_DEPTH_L;
              end
              h264sps_pkg::ST_SEP_PLANE: step_nxt = h264sps_pkg::ST_DEPTH_L;
              h264sps_pkg::ST_DEPTH_L:   step_nxt = h264sps_pkg::ST_DEPTH_C;
              h264sps_pkg::ST_DEPTH_C:   step_nxt = h264sps_pkg::ST_BYPASS;
              h264sps_pkg::ST_BYPASS:    step_nxt = h264sps_pkg::ST_MATRIX;
              h264sps_pkg::ST_MATRIX: begin
                list_nxt = '0;
                step_nxt = v[0] ? h264sps_pkg::ST_LIST_FLAG :
                                  h264sps_pkg::ST_LOG2_FRAME;
              end
              h264sps_pkg::ST_LIST_FLAG: begin
                if (v[0]) begin
                  entry_nxt = '0; lscale_nxt = 8'd8; nscale_nxt = 8'd8;
                  step_nxt = h264sps_pkg::ST_DELTA;
                end else begin
                  list_nxt = list_r + 4'd1;
                  step_nxt = ({4'd0, list_nxt} >= ccount_r) ?
                             h264sps_pkg::ST_LOG2_FRAME : h264sps_pkg::ST_LIST_FLAG;
                end
              end
              h264sps_pkg::ST_DELTA: begin
                nscale_nxt = nsum;
                if (nsum != 8'd0) lscale_nxt = nsum;
                entry_nxt = entry_r + 7'd1;
                if (nsum == 8'd0 ||
                    entry_nxt >= ((list_r < 4'd6) ? 7'd16 : 7'd64)) begin
                  list_nxt = list_r + 4'd1;
                  step_nxt = ({4'd0, list_nxt} >= ccount_r) ?
                             h264sps_pkg::ST_LOG2_FRAME : h264sps_pkg::ST_LIST_FLAG;
                end
              end
              h264sps_pkg::ST_LOG2_FRAME: step_nxt = h264sps_pkg::ST_POC_TYPE;
              h264sps_pkg::ST_POC_TYPE:
                step_nxt = (v == 33'd0) ? h264sps_pkg::ST_POC_LSB :
                           (v == 33'd1) ? h264sps_pkg::ST_DELTA_ZERO :
                                          h264sps_pkg::ST_MAX_REFS;
              h264sps_pkg::ST_POC_LSB:    step_nxt = h264sps_pkg::ST_MAX_REFS;
              h264sps_pkg::ST_DELTA_ZERO: step_nxt = h264sps_pkg::ST_OFF_NONREF;
              h264sps_pkg::ST_OFF_NONREF: step_nxt = h264sps_pkg::ST_OFF_TB;
              h264sps_pkg::ST_OFF_TB:     step_nxt = h264sps_pkg::ST_CYCLE_N;
              h264sps_pkg::ST_CYCLE_N: begin
                if (v > 33'd255) err_nxt = h264sps_pkg::STATUS_ERR;
                else begin
                  ccount_nxt = v[7:0];
                  step_nxt = (v == 33'd0) ? h264sps_pkg::ST_MAX_REFS :
                                            h264sps_pkg::ST_CYCLE_OFF;
                end
              end
              h264sps_pkg::ST_CYCLE_OFF: begin
                ccount_nxt = ccount_r - 8'd1;
                if (ccount_nxt == 8'd0) step_nxt = h264sps_pkg::ST_MAX_REFS;
              end
              h264sps_pkg::ST_MAX_REFS: step_nxt = h264sps_pkg::ST_GAPS;
              h264sps_pkg::ST_GAPS:     step_nxt = h264sps_pkg::ST_WIDTH;
              h264sps_pkg::ST_WIDTH: begin
                if (v > 33'd65535) err_nxt = h264sps_pkg::STATUS_ERR;
                else begin
                  wmb_nxt = v[15:0];
                  step_nxt = h264sps_pkg::ST_HEIGHT;
                end
              end
              h264sps_pkg::ST_HEIGHT: begin
                if (v > 33'd65535) err_nxt = h264sps_pkg::STATUS_ERR;
                else begin
                  hun_nxt = v[15:0];
                  step_nxt = h264sps_pkg::ST_FRAME_ONLY;
                end
              end
              h264sps_pkg::ST_FRAME_ONLY: begin
                fonly_nxt = v[0];
                step_nxt = v[0] ? h264sps_pkg::ST_DIRECT : h264sps_pkg::ST_MBAFF;
              end
              h264sps_pkg::ST_MBAFF:  step_nxt = h264sps_pkg::ST_DIRECT;
              h264sps_pkg::ST_DIRECT: step_nxt = h264sps_pkg::ST_CROP;
              h264sps_pkg::ST_CROP:
                step_nxt = v[0] ? h264sps_pkg::ST_CROP_L : h264sps_pkg::ST_VUI;
              h264sps_pkg::ST_CROP_L, h264sps_pkg::ST_CROP_R,
              h264sps_pkg::ST_CROP_T, h264sps_pkg::ST_CROP_B: begin
                if (v > 33'd65535) err_nxt = h264sps_pkg::STATUS_ERR;
                else begin
                  crop_nxt[step_r[1:0]] = v[15:0];
                  step_nxt = h264sps_pkg::step_t'(step_r + 6'd1);
                end
              end
              h264sps_pkg::ST_VUI: step_nxt = h264sps_pkg::ST_DONE;
              default: ;
            endcase
          end
        end
      end

      h264sps_pkg::SEQ_OUT: begin
        case (ostep_r)
          2'd0: begin
            wacc_nxt = sum_a;  // mbs
            hacc_nxt = sum_b;  // left+right
            ostep_nxt = 2'd1;
          end
          2'd1: begin
            // width = mbs*16 - 2*(l+r); store height sources
            w = {wacc_r[16:0], 4'd0} - {hacc_r[19:0], 1'b0};
            wacc_nxt = w[20] ? 20'hFFFFF : ((w > 21'd65535) ? 20'hFFFFF : w[19:0]);
            hacc_nxt = sum_b;
            odata_nxt[15:0] = w[15:0];
            odata_nxt[39:16] = {sum_a[19:0], 4'd0};  // rows in units, parked
            ostep_nxt = 2'd2;
          end
          2'd2: begin
            hc = {1'b0, odata_r[36:16]};
            h  = (fonly_r ? hc : {hc[20:0], 1'b0}) - {1'b0, hacc_r[19:0], 1'b0};
            wc = {1'b0, wacc_r};
            ovf = (wc == 21'h0FFFFF) || h[21] || (h > 22'd65535);
            if (err_r != h264sps_pkg::STATUS_OK)
              odata_nxt = {6'd0, h264sps_pkg::STATUS_ERR, 32'd0};
            else if (step_r != h264sps_pkg::ST_DONE)
              odata_nxt = {6'd0, h264sps_pkg::STATUS_SHORT, 32'd0};
            else if (ovf)
              odata_nxt = {6'd0, h264sps_pkg::STATUS_ERR, 32'd0};
            else
              odata_nxt = {6'd0, h264sps_pkg::STATUS_OK, h[15:0], odata_r[15:0]};
            ostep_nxt = 2'd3;
          end
          default: begin
            if (out_tready) begin
              seq_nxt = h264sps_pkg::SEQ_IDLE;
              skip_nxt = '0; step_nxt = h264sps_pkg::ST_PROFILE;
              zrun_nxt = '0; code_nxt = '0; left_nxt = '0; list_nxt = '0;
              entry_nxt = '0; lscale_nxt = 8'd8; nscale_nxt = 8'd8;
              ccount_nxt = '0; prof_nxt = '0; fonly_nxt = 1'b0;
              wmb_nxt = '0; hun_nxt = '0; err_nxt = '0;
              for (int i = 0; i < 4; i++) crop_nxt[i] = '0;
            end
          end
        endcase
      end

      default: seq_nxt = h264sps_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= h264sps_pkg::SEQ_IDLE;
      step_r <= h264sps_pkg::ST_PROFILE;
      hdr_r <= h264sps_pkg::HeaderBytesReset;
      skip_r <= '0; bit_r <= '0; last_r <= 1'b0; zrun_r <= '0;
      code_r <= '0; left_r <= '0; list_r <= '0; entry_r <= '0;
      lscale_r <= 8'd8; nscale_r <= 8'd8; ccount_r <= '0; prof_r <= '0;
      fonly_r <= 1'b0; wmb_r <= '0; hun_r <= '0; err_r <= '0;
      ostep_r <= '0;
      for (int i = 0; i < 4; i++) crop_r[i] <= '0;
    end else begin
      seq_r <= seq_nxt; step_r <= step_nxt; skip_r <= skip_nxt;
      bit_r <= bit_nxt; last_r <= last_nxt; zrun_r <= zrun_nxt;
      code_r <= code_nxt; left_r <= left_nxt; list_r <= list_nxt;
      entry_r <= entry_nxt; lscale_r <= lscale_nxt; nscale_r <= nscale_nxt;
      ccount_r <= ccount_nxt; prof_r <= prof_nxt; fonly_r <= fonly_nxt;
      wmb_r <= wmb_nxt; hun_r <= hun_nxt; err_r <= err_nxt;
      ostep_r <= ostep_nxt;
      for (int i = 0; i < 4; i++) crop_r[i] <= crop_nxt[i];
      if (cfg_valid && cfg_ready) hdr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    wacc_r  <= wacc_nxt;
    hacc_r  <= hacc_nxt;
    odata_r <= odata_nxt;
  end

endmodule
`default_nettype wire

// File: design/h264sps_checker.sv
// Port-level checker for the SPS dimension parser, bound to the top level.
// Depends on h264_sps_dimension_parser_top.
`default_nettype none
module h264sps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // a result only shows while no input is taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");

  // a held result keeps its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // status is never the unused code
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd3) else $error("bad status");

  // non-ok status carries zero size
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] != 2'd0 |-> out_tdata[31:0] == 32'd0)
    else $error("size on error");

  // a non-last transfer never yields a result next cycle
  a_nolast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !out_tvalid)
    else $error("result without last byte");

endmodule

bind h264_sps_dimension_parser_top h264sps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire
